// ===== rtl/ilid_pkg.sv =====
// Shared widths, command codes and status codes for the indexed list unit.
`default_nettype none

package ilid_pkg;

    // Field widths of the item and result channels
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 5;
    localparam int CNT_W  = 5;
    localparam int ST_W   = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;

endpackage

`default_nettype wire

// ===== rtl/ilid_store.sv =====
// Element store: one write port, one read port with registered read data.
`default_nettype none

module ilid_store #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic           clk,
    input  wire logic           wr_en,
    input  wire logic [AW-1:0]  wr_addr,
    input  wire ilid_pkg::data_t wr_data,
    input  wire logic           rd_en,
    input  wire logic [AW-1:0]  rd_addr,
    output ilid_pkg::data_t     rd_data
);

    ilid_pkg::data_t mem_reg [DEPTH];
    ilid_pkg::data_t rd_data_reg;

    // Write one entry and read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_insert_delete_unit.sv =====
// Append, remove last, insert at p = count, delete at p = count - 1, rejected and unused
// commands have the result registered at the accept edge. Read passes through S_READ.
// Insert at p < count goes S_MOVE, S_FLUSH, S_PUT; delete at p < count - 1 S_MOVE, S_FLUSH.
// Items are taken one at a time; insert and delete move one entry per cycle through the
// single store read port, and a held result stalls the next item until it is taken.
// Reset clears the count, the sequencer and the result slot; the store is not cleared.
`default_nettype none

module indexed_list_insert_delete_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [ilid_pkg::CMD_W-1:0]     cmd,
    input  wire logic [ilid_pkg::POS_W-1:0]     position,
    input  wire logic signed [ilid_pkg::DATA_W-1:0] elem_value,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [ilid_pkg::DATA_W-1:0]  read_value,
    output logic [ilid_pkg::CNT_W-1:0]          count,
    output logic [ilid_pkg::ST_W-1:0]           status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > ilid_pkg::POS_W) ? CW : ilid_pkg::POS_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MOVE  = 5'b00010,
        S_FLUSH = 5'b00100,
        S_PUT   = 5'b01000,
        S_READ  = 5'b10000
    } state_t;

    // Control state
    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;

    // Sequencer payload
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        prev_reg, prev_next;
    logic [AW-1:0]        wa_reg, wa_next;
    logic [AW-1:0]        end_reg, end_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic                 ins_reg, ins_next;
    ilid_pkg::data_t      val_reg, val_next;

    // Result slot payload
    ilid_pkg::data_t               rv_reg, rv_next;
    logic [ilid_pkg::CNT_W-1:0]    cnt_out_reg, cnt_out_next;
    logic [ilid_pkg::ST_W-1:0]     st_reg, st_next;

    // Store port
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    ilid_pkg::data_t      wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    ilid_pkg::data_t      rd_data;

    // Decode helpers
    logic                 in_acc;
    logic                 done;
    logic                 full;
    logic [XW-1:0]        pos_x;
    logic [XW-1:0]        cnt_x;
    logic [CW-1:0]        cnt_m1;
    logic [AW-1:0]        cnt_a;
    logic [AW-1:0]        pos_a;
    logic [AW-1:0]        idx_step;

    ilid_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Take a new item only in idle with the result slot free or draining
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;

    assign full   = (cnt_reg == CW'(DEPTH));
    assign pos_x  = XW'(position);
    assign cnt_x  = XW'(cnt_reg);
    assign cnt_m1 = cnt_reg - CW'(1);
    assign cnt_a  = cnt_reg[AW-1:0];
    assign pos_a  = AW'(position);

    // Shared index stepper: walk down for insert, up for delete
    assign idx_step = ins_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));

    // Sequence commands and drive the store port
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        wa_next        = wa_reg;
        end_next       = end_reg;
        pos_next       = pos_reg;
        ins_next       = ins_reg;
        val_next       = val_reg;
        rv_next        = rv_reg;
        cnt_out_next   = cnt_out_reg;
        st_next        = st_reg;
        wr_en          = 1'b0;
        wr_addr        = wa_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        done           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    pos_next = pos_a;
                    val_next = elem_value;
                    rv_next  = '0;
                    st_next  = ilid_pkg::ST_OK;
                    unique case (cmd)
                        ilid_pkg::CMD_APPEND:
                        begin
                            done = 1'b1;
                            if (full)
                            begin
                                st_next = ilid_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = cnt_a;
                                wr_data  = elem_value;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        ilid_pkg::CMD_INSERT:
                        begin
                            if (full)
                            begin
                                done    = 1'b1;
                                st_next = ilid_pkg::ST_FULL;
                            end
                            else if (pos_x > cnt_x)
                            begin
                                done    = 1'b1;
                                st_next = ilid_pkg::ST_BAD;
                            end
                            else if (pos_x == cnt_x)
                            begin
                                done     = 1'b1;
                                wr_en    = 1'b1;
                                wr_addr  = cnt_a;
                                wr_data  = elem_value;
                                cnt_next = cnt_reg + CW'(1);
                            end
                            else
                            begin
                                // shift entries up, top entry first
                                idx_next   = cnt_m1[AW-1:0];
                                prev_next  = cnt_a;
                                end_next   = pos_a;
                                ins_next   = 1'b1;
                                pend_next  = 1'b0;
                                state_next = S_MOVE;
                            end
                        end
                        ilid_pkg::CMD_DELETE:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                done    = 1'b1;
                                st_next = ilid_pkg::ST_BAD;
                            end
                            else if (pos_x == XW'(cnt_m1))
                            begin
                                done     = 1'b1;
                                cnt_next = cnt_m1;
                            end
                            else
                            begin
                                // shift entries down, lowest entry first
                                idx_next   = pos_a + AW'(1);
                                prev_next  = pos_a;
                                end_next   = cnt_m1[AW-1:0];
                                ins_next   = 1'b0;
                                pend_next  = 1'b0;
                                state_next = S_MOVE;
                            end
                        end
                        ilid_pkg::CMD_POP:
                        begin
                            done = 1'b1;
                            if (cnt_reg == '0)
                            begin
                                st_next = ilid_pkg::ST_BAD;
                            end
                            else
                            begin
                                cnt_next = cnt_m1;
                            end
                        end
                        ilid_pkg::CMD_READ:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                done    = 1'b1;
                                st_next = ilid_pkg::ST_BAD;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = pos_a;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_MOVE:
            begin
                // read the next entry, write the entry from the previous read
                rd_en     = 1'b1;
                rd_addr   = idx_reg;
                wr_en     = pend_reg;
                wa_next   = prev_reg;
                prev_next = idx_reg;
                pend_next = 1'b1;
                if (idx_reg == end_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next = idx_step;
                end
            end
            S_FLUSH:
            begin
                // write the last moved entry
                wr_en     = 1'b1;
                pend_next = 1'b0;
                if (ins_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cnt_next   = cnt_m1;
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PUT:
            begin
                // drop the new value into the opened slot
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = val_reg;
                cnt_next   = cnt_reg + CW'(1);
                done       = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                rv_next    = rd_data;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Load the result slot
        if (done)
        begin
            out_valid_next = 1'b1;
            cnt_out_next   = ilid_pkg::CNT_W'(cnt_next);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        prev_reg    <= prev_next;
        wa_reg      <= wa_next;
        end_reg     <= end_next;
        pos_reg     <= pos_next;
        ins_reg     <= ins_next;
        val_reg     <= val_next;
        rv_reg      <= rv_next;
        cnt_out_reg <= cnt_out_next;
        st_reg      <= st_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = rv_reg;
    assign count      = cnt_out_reg;
    assign status     = st_reg;

    // Count never passes the store depth
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("element count beyond depth");

    // Moves only touch entries inside the list
    a_move_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |-> (CW'(idx_reg) < cnt_reg))
        else $error("move index outside the list");

    // A full flag goes out with a full count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (st_reg == ilid_pkg::ST_FULL))
            |-> (cnt_out_reg == ilid_pkg::CNT_W'(DEPTH)))
        else $error("full status with count below depth");

    // Count moves by one and only together with a new result
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> (out_valid_reg &&
            ((cnt_reg == $past(cnt_reg) + CW'(1)) ||
             (cnt_reg == $past(cnt_reg) - CW'(1)))))
        else $error("count changed without a result");

endmodule

`default_nettype wire
